@@ sv/jmc_pkg.sv @@
// ---------------------------------------------------------------------------
// jmc_pkg
// shared types and constants of the jpeg marker carver
// ---------------------------------------------------------------------------
package jmc_pkg;

  localparam logic [7:0] MARK_FF = 8'hFF;
  localparam logic [7:0] MARK_D8 = 8'hD8;
  localparam logic [7:0] MARK_D9 = 8'hD9;

  localparam int NUM_W   = 32;   // artifact_number field width
  localparam int OFS_W   = 48;   // start_offset / artifact_size field width
  localparam int QDEPTH  = 4;    // decoupling queue entries

  // width of the packed result tdata: byte, number, start, size
  localparam int OUT_DATA_W = 8 + NUM_W + OFS_W + OFS_W;

  // one queue entry: a single result, or a whole start signature (three results)
  typedef struct packed {
    logic             is_start;
    logic [7:0]       data_byte;
    logic             last;
    logic [NUM_W-1:0] number;
    logic [OFS_W-1:0] start_ofs;
    logic [OFS_W-1:0] size;
  } jmc_rec_t;

  typedef enum logic [1:0] {
    BEAT_HDR0 = 2'd0,
    BEAT_HDR1 = 2'd1,
    BEAT_HDR2 = 2'd2
  } jmc_beat_t;

endpackage

@@ sv/jmc_front.sv @@
// ---------------------------------------------------------------------------
// jmc_front
// per-byte scanner: tracks offset, window and open artifact, issues records
// ---------------------------------------------------------------------------
module jmc_front #(
  parameter int OFFSET_BITS = 48,
  parameter int COUNT_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             q_full,
  output logic             push_valid,
  output jmc_pkg::jmc_rec_t push_rec
);
  import jmc_pkg::*;

  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic                   active_r, active_nxt;
  logic [7:0]             prev_r, prev2_r;
  logic [1:0]             fill_r, fill_nxt;
  logic                   take;
  logic                   sig_hit, end_hit;
  logic [OFFSET_BITS-1:0] size_val;
  logic [63:0]            num64, start64, size64;

  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;

  assign sig_hit  = !active_r && (fill_r == 2'd2) && (prev2_r == MARK_FF) &&
                    (prev_r == MARK_D8) && (in_tdata == MARK_FF);
  assign end_hit  = active_r && (prev_r == MARK_FF) && (in_tdata == MARK_D9);
  assign size_val = offset_r - start_r + OFFSET_BITS'(1);

  always_comb begin
    start_nxt  = start_r;
    count_nxt  = count_r;
    active_nxt = active_r;
    fill_nxt   = (fill_r == 2'd2) ? fill_r : fill_r + 2'd1;
    if (end_hit) begin
      active_nxt = 1'b0;
      fill_nxt   = 2'd0;
    end else if (sig_hit) begin
      start_nxt  = offset_r - OFFSET_BITS'(2);
      active_nxt = 1'b1;
      if (count_r != '1) begin
        count_nxt = count_r + COUNT_BITS'(1);
      end
    end
  end

  // fit the internal widths onto the fixed result fields
  assign num64   = 64'(count_nxt);
  assign start64 = 64'(start_nxt);
  assign size64  = end_hit ? 64'(size_val) : 64'd0;

  assign push_valid         = take && (active_r || sig_hit);
  assign push_rec.is_start  = sig_hit;
  assign push_rec.data_byte = in_tdata;
  assign push_rec.last      = end_hit;
  assign push_rec.number    = num64[NUM_W-1:0];
  assign push_rec.start_ofs = start64[OFS_W-1:0];
  assign push_rec.size      = size64[OFS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      start_r  <= '0;
      count_r  <= '0;
      active_r <= 1'b0;
      prev_r   <= '0;
      prev2_r  <= '0;
      fill_r   <= '0;
    end else if (take) begin
      offset_r <= offset_r + OFFSET_BITS'(1);
      start_r  <= start_nxt;
      count_r  <= count_nxt;
      active_r <= active_nxt;
      prev_r   <= in_tdata;
      prev2_r  <= prev_r;
      fill_r   <= fill_nxt;
    end
  end

endmodule

@@ sv/jmc_queue.sv @@
// ---------------------------------------------------------------------------
// jmc_queue
// small record fifo between scanner and output sequencer
// ---------------------------------------------------------------------------
module jmc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jmc_pkg::jmc_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output jmc_pkg::jmc_rec_t head_rec
);
  import jmc_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  jmc_rec_t       mem [QDEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full      = (cnt_r == CW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ sv/jmc_back.sv @@
// ---------------------------------------------------------------------------
// jmc_back
// output sequencer: expands start records into three beats, output register
// ---------------------------------------------------------------------------
module jmc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  jmc_pkg::jmc_rec_t                 head_rec,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [jmc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);
  import jmc_pkg::*;

  jmc_beat_t               beat_r, beat_nxt;
  logic                    valid_r;
  logic [OUT_DATA_W-1:0]   data_r, data_nxt;
  logic                    last_r, last_nxt;
  logic                    first_r, first_nxt;
  logic                    load;
  logic [7:0]              beat_byte;

  assign load = q_not_empty && (!valid_r || out_tready);

  always_comb begin
    beat_nxt  = beat_r;
    q_pop     = 1'b0;
    beat_byte = head_rec.data_byte;
    first_nxt = 1'b0;
    last_nxt  = head_rec.last;
    if (head_rec.is_start) begin
      last_nxt = 1'b0;
      unique case (beat_r)
        BEAT_HDR0: begin
          beat_byte = MARK_FF;
          first_nxt = 1'b1;
          beat_nxt  = BEAT_HDR1;
        end
        BEAT_HDR1: begin
          beat_byte = MARK_D8;
          beat_nxt  = BEAT_HDR2;
        end
        BEAT_HDR2: begin
          beat_byte = MARK_FF;
          beat_nxt  = BEAT_HDR0;
          q_pop     = load;
        end
        default: begin
          beat_nxt = BEAT_HDR0;
        end
      endcase
    end else begin
      q_pop = load;
    end
    if (!load) begin
      beat_nxt = beat_r;
    end
    data_nxt = {head_rec.size, head_rec.start_ofs, head_rec.number, beat_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= BEAT_HDR0;
      valid_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r  <= data_nxt;
      last_r  <= last_nxt;
      first_r <= first_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = first_r;

endmodule

@@ sv/jpeg_marker_carver.sv @@
// ---------------------------------------------------------------------------
// jpeg_marker_carver
// streaming carver for jpeg files embedded in a raw byte stream
// ---------------------------------------------------------------------------
// One raw byte enters per transfer and the block takes one byte every cycle
// while its record queue is not full. While no artifact is open it looks for
// FF D8 FF among bytes received since the last artifact ended; on a hit it
// sends the three signature bytes, the first one tagged in tuser. While open,
// every byte goes out, and a D9 right after an FF closes the artifact with
// tlast and the artifact size. Results leave at one per cycle while out_tready
// is high; a start signature adds two extra result beats, which a four-entry
// record queue between the scanner and the output sequencer absorbs (the two
// signature bytes before it produce nothing), so the input only stalls when
// the output side is held back. Each record passes the queue and then the
// output register. The stream offset wraps at OFFSET_BITS and the artifact
// number saturates at its all-ones value; an unclosed artifact stays open.
// ---------------------------------------------------------------------------
module jpeg_marker_carver #(
  parameter int OFFSET_BITS = 48,
  parameter int COUNT_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input byte stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,    // [7:0] data_byte
  // carved result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] carved_byte, [39:8] artifact_number, [87:40] start_offset,
  // [135:88] artifact_size
  output logic [jmc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,   // last_flag
  output logic                           out_tuser    // first_flag
);
  import jmc_pkg::*;

  // scanner to queue
  logic     push_valid;
  jmc_rec_t push_rec;
  logic     q_full;

  // queue to sequencer
  logic     q_not_empty;
  logic     q_pop;
  jmc_rec_t head_rec;

  // front: offset counting, signature window, artifact open/close
  jmc_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_rec   (push_rec)
  );

  // record queue decoupling the two sides
  jmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  // back: beat expansion and registered output
  jmc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head_rec    (head_rec),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  // the scanner never issues a record into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !q_full)
    else $error("record pushed into full queue");

  // a first-tagged beat is always the FF of a signature
  a_first_is_ff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[7:0] == MARK_FF) && !out_tlast)
    else $error("first beat is not FF");

  // a closing beat carries D9
  a_last_is_d9: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[7:0] == MARK_D9))
    else $error("last beat is not D9");

  // the D8 of the signature follows its FF with no gap
  a_d8_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser) |=>
      (out_tvalid && (out_tdata[7:0] == MARK_D8)))
    else $error("signature beats split");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming jpeg marker carver
// ---------------------------------------------------------------------------
// Raw bytes go in through the input stream. A local scan model works out the
// carved results for every accepted byte, and each result transfer is checked
// against the oldest one still pending. A short directed table comes first:
// header/footer overlap, back-to-back artifacts, markers inside an artifact
// and bytes just after a close. Random traffic follows, mostly whole artifacts
// with random bodies plus noise and broken signatures, under several idle
// and stall mixes. A long output hold-off fills the block up.
// ---------------------------------------------------------------------------
module tb_top;
  import jmc_pkg::*;

  localparam int OFS_BITS = 48;       // stream offset width
  localparam int CNT_BITS = 32;       // artifact number width
  localparam int LIMIT    = 500000;   // cycle budget for the whole run
  localparam int TAIL     = 20;       // quiet cycles after the last result
  localparam int DIR_ROWS = 25;

  // one carved result as it appears on the output stream
  typedef struct packed {
    logic [7:0]       carved;
    logic             is_first;
    logic             is_last;
    logic [NUM_W-1:0] num;
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] size;
  } carve_res_t;

  // one byte to send; typed rows carry their own expected results
  typedef struct packed {
    logic [7:0]       b;
    logic             typed;
    logic [1:0]       n;        // typed result count: 0, 1 (close) or 3 (start)
    logic [NUM_W-1:0] num;
    logic [OFS_W-1:0] st;
    logic [OFS_W-1:0] sz;
  } scan_item_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = 8'h00;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  // scan model state
  logic [OFS_BITS-1:0] pos_ofs    = '0;
  logic                in_jpeg    = 1'b0;
  logic [OFS_BITS-1:0] open_start = '0;
  logic [7:0]          last1      = 8'h00;
  logic [7:0]          last2      = 8'h00;
  logic [1:0]          win_fill   = 2'd0;
  logic [CNT_BITS-1:0] jpeg_count = '0;

  carve_res_t step_res[$];     // results of the byte just scanned
  carve_res_t pending[$];      // results still owed by the block
  scan_item_t tx_q[$];         // bytes waiting to be offered
  scan_item_t cur_item;        // byte currently on the input bus
  scan_item_t dir_tab[DIR_ROWS];

  bit in_took        = 1'b0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int bad_cnt        = 0;
  int bytes_in       = 0;
  int prod_cnt       = 0;      // accepted bytes that caused at least one result
  int res_cnt        = 0;
  int cyc            = 0;

  jpeg_marker_carver #(
    .OFFSET_BITS(OFS_BITS),
    .COUNT_BITS (CNT_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic carve_res_t mk_res(input logic [7:0] b, input logic f, input logic l,
                                        input logic [NUM_W-1:0] num,
                                        input logic [OFS_W-1:0] st,
                                        input logic [OFS_W-1:0] sz);
    carve_res_t r;
    r.carved   = b;
    r.is_first = f;
    r.is_last  = l;
    r.num      = num;
    r.start    = st;
    r.size     = sz;
    return r;
  endfunction

  function automatic scan_item_t mk_item(input logic [7:0] b, input logic typed,
                                         input logic [1:0] n, input int num,
                                         input int st, input int sz);
    scan_item_t it;
    it.b     = b;
    it.typed = typed;
    it.n     = n;
    it.num   = NUM_W'(num);
    it.st    = OFS_W'(st);
    it.sz    = OFS_W'(sz);
    return it;
  endfunction

  // scan one byte: update the carver state, leave its results in step_res
  function automatic void carve_predict(input logic [7:0] b);
    logic [OFS_BITS-1:0] here;
    logic [OFS_BITS-1:0] len;
    here = pos_ofs;
    step_res.delete();
    if (in_jpeg) begin
      if (last1 == MARK_FF && b == MARK_D9) begin
        // footer closes the artifact, size wraps with the offset
        len = here - open_start + 1'b1;
        step_res.insert(step_res.size(),
                        mk_res(b, 1'b0, 1'b1, jpeg_count, open_start, len));
        in_jpeg  = 1'b0;
        win_fill = 2'd0;
      end else begin
        step_res.insert(step_res.size(),
                        mk_res(b, 1'b0, 1'b0, jpeg_count, open_start, '0));
        if (win_fill < 2'd2) win_fill++;
      end
    end else begin
      // signature only counts when both held bytes came after the last close
      if (win_fill == 2'd2 && last2 == MARK_FF && last1 == MARK_D8 && b == MARK_FF) begin
        open_start = here - 2'd2;
        if (jpeg_count != {CNT_BITS{1'b1}}) jpeg_count++;
        in_jpeg = 1'b1;
        step_res.insert(step_res.size(),
                        mk_res(last2, 1'b1, 1'b0, jpeg_count, open_start, '0));
        step_res.insert(step_res.size(),
                        mk_res(last1, 1'b0, 1'b0, jpeg_count, open_start, '0));
        step_res.insert(step_res.size(),
                        mk_res(b, 1'b0, 1'b0, jpeg_count, open_start, '0));
      end
      if (win_fill < 2'd2) win_fill++;
    end
    last2   = last1;
    last1   = b;
    pos_ofs = here + 1'b1;
  endfunction

  function automatic void note_bad(input string what);
    bad_cnt++;
    if (bad_cnt <= 10) $display("mismatch %0d: %s", bad_cnt, what);
  endfunction

  // input driver: new byte or idle cycle at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      in_took = 1'b0;
      if (tx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = tx_q.pop_front();
        in_tdata  <= cur_item.b;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // input transfer: scan the byte and queue what it owes
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      in_took = 1'b1;
      bytes_in++;
      carve_predict(cur_item.b);
      if (step_res.size() != 0) prod_cnt++;
      if (cur_item.typed) begin
        // hand-written expectation replaces the scan model for this row
        if (cur_item.n == 2'd3) begin
          pending.insert(pending.size(),
                         mk_res(MARK_FF, 1'b1, 1'b0, cur_item.num, cur_item.st, '0));
          pending.insert(pending.size(),
                         mk_res(MARK_D8, 1'b0, 1'b0, cur_item.num, cur_item.st, '0));
          pending.insert(pending.size(),
                         mk_res(cur_item.b, 1'b0, 1'b0, cur_item.num, cur_item.st, '0));
        end else if (cur_item.n == 2'd1) begin
          pending.insert(pending.size(),
                         mk_res(cur_item.b, 1'b0, 1'b1, cur_item.num, cur_item.st,
                                cur_item.sz));
        end
      end else begin
        foreach (step_res[k]) pending.insert(pending.size(), step_res[k]);
      end
    end
  end

  // result transfer: compare against the oldest pending result
  always @(posedge clk) begin
    carve_res_t want;
    carve_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      res_cnt++;
      got = mk_res(out_tdata[7:0], out_tuser, out_tlast, out_tdata[8 +: NUM_W],
                   out_tdata[8+NUM_W +: OFS_W], out_tdata[8+NUM_W+OFS_W +: OFS_W]);
      if (pending.size() == 0) begin
        note_bad($sformatf("unexpected result byte %h first %b last %b num %0d start %0d size %0d",
                           got.carved, got.is_first, got.is_last, got.num, got.start,
                           got.size));
      end else begin
        want = pending.pop_front();
        if (got.carved !== want.carved || got.is_first !== want.is_first ||
            got.is_last !== want.is_last || got.num !== want.num ||
            got.start !== want.start || got.size !== want.size) begin
          note_bad($sformatf(
            "exp byte %h first %b last %b num %0d start %0d size %0d / got byte %h first %b last %b num %0d start %0d size %0d",
            want.carved, want.is_first, want.is_last, want.num, want.start, want.size,
            got.carved, got.is_first, got.is_last, got.num, got.start, got.size));
        end
      end
    end
  end

  // run budget
  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cyc, pending.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    tx_q.insert(tx_q.size(), mk_item(b, 1'b0, 2'd0, 0, 0, 0));
  endtask

  // FF D8 FF, a marker-heavy random body, then the closing FF D9
  task automatic queue_artifact(input int body_len);
    queue_byte(MARK_FF);
    queue_byte(MARK_D8);
    queue_byte(MARK_FF);
    repeat (body_len) begin
      case ($urandom_range(5))
        0:       queue_byte(MARK_FF);
        1:       queue_byte(MARK_D8);
        2:       queue_byte(MARK_D9);
        default: queue_byte(8'($urandom_range(255)));
      endcase
    end
    queue_byte(MARK_FF);
    queue_byte(MARK_D9);
  endtask

  // mostly whole artifacts, the rest noise and broken signatures
  task automatic queue_chunk();
    int kind;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      repeat ($urandom_range(2)) queue_byte(8'($urandom_range(255)));
      queue_artifact($urandom_range(10));
    end else if (kind == 7) begin
      // signature broken at its third byte
      queue_byte(MARK_FF);
      queue_byte(MARK_D8);
      queue_byte(8'($urandom_range(254)));
    end else if (kind == 8) begin
      repeat ($urandom_range(4, 1)) queue_byte(8'($urandom_range(255)));
    end else begin
      // footer cut short, artifact stays open into the next chunk
      queue_byte(MARK_FF);
      queue_byte(MARK_D8);
      queue_byte(MARK_FF);
      repeat ($urandom_range(4)) queue_byte(8'($urandom_range(255)));
      queue_byte(MARK_FF);
    end
  endtask

  // sender pauses until every owed result has come out
  task automatic drain();
    while (tx_q.size() != 0 || in_tvalid) @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  // close a leftover open artifact so the next phase starts idle
  task automatic close_open();
    if (in_jpeg) begin
      queue_byte(MARK_FF);
      queue_byte(MARK_D9);
      drain();
    end
  endtask

  task automatic run_random(input int send_pct, input int recv_pct, input int target);
    int goal;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    goal = bytes_in + target;
    while (bytes_in < goal) begin
      queue_chunk();
      while (tx_q.size() > 6) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    // directed rows: offsets count from 0 after reset
    dir_tab[0]  = mk_item(8'h00,   1'b1, 2'd0, 0, 0, 0);   // nothing while window fills
    dir_tab[1]  = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[2]  = mk_item(MARK_D8, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[3]  = mk_item(MARK_FF, 1'b1, 2'd3, 1, 1, 0);   // first artifact at offset 1
    dir_tab[4]  = mk_item(MARK_D9, 1'b1, 2'd1, 1, 1, 4);   // footer right on the header FF
    dir_tab[5]  = mk_item(MARK_D8, 1'b0, 2'd0, 0, 0, 0);   // bytes just after the close
    dir_tab[6]  = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[7]  = mk_item(MARK_D8, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[8]  = mk_item(MARK_FF, 1'b1, 2'd3, 2, 6, 0);   // second artifact at offset 6
    dir_tab[9]  = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);   // a new signature inside is data
    dir_tab[10] = mk_item(MARK_D8, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[11] = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[12] = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[13] = mk_item(MARK_D9, 1'b1, 2'd1, 2, 6, 8);
    dir_tab[14] = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[15] = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[16] = mk_item(MARK_D8, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[17] = mk_item(MARK_FF, 1'b1, 2'd3, 3, 15, 0);  // FF FF D8 FF starts at the second FF
    dir_tab[18] = mk_item(8'h00,   1'b0, 2'd0, 0, 0, 0);
    dir_tab[19] = mk_item(MARK_D9, 1'b0, 2'd0, 0, 0, 0);   // D9 without FF in front is data
    dir_tab[20] = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[21] = mk_item(MARK_FF, 1'b0, 2'd0, 0, 0, 0);
    dir_tab[22] = mk_item(MARK_D9, 1'b1, 2'd1, 3, 15, 8);
    dir_tab[23] = mk_item(8'h7F,   1'b0, 2'd0, 0, 0, 0);   // idle noise
    dir_tab[24] = mk_item(8'h80,   1'b0, 2'd0, 0, 0, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    for (int i = 0; i < DIR_ROWS; i++) tx_q.insert(tx_q.size(), dir_tab[i]);
    drain();

    // random traffic under three idle and stall mixes
    run_random(0, 0, 40);
    run_random(80, 0, 40);
    run_random(0, 80, 40);

    // output held off while the sender keeps offering: queue fills, input stalls
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    close_open();
    hold_cycles    = 120;
    repeat (8) queue_artifact($urandom_range(3));
    drain();

    run_random(12, 12, 40);

    repeat (TAIL) @(posedge clk);
    if (pending.size() != 0) note_bad($sformatf("%0d results never came", pending.size()));

    $display("scanned %0d bytes (%0d producing output), checked %0d carved results",
             bytes_in, prod_cnt, res_cnt);
    $display("covered header/footer overlap, idle and stall mixes, output hold-off");
    if (bad_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", bad_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/jmc_pkg.sv
sv/jmc_front.sv
sv/jmc_queue.sv
sv/jmc_back.sv
sv/jpeg_marker_carver.sv
tb/tb_top.sv
